/* design/assert_macros.svh */
// Assertion macros shared by the shift and rotate unit modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check that an implication holds at every clock edge out of reset.
`define SRU_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
// Check that a condition never holds out of reset.
`define SRU_NEVER(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");
`else
`define SRU_ASSERT(label, prop)
`define SRU_NEVER(label, cond)
`endif
`endif

/* design/sru_pkg.sv */
// Types, operation codes and constants of the shift and rotate unit.
package sru_pkg;

    // Operation codes of the kind field
    localparam logic [2:0] KIND_RCL   = 3'd0;
    localparam logic [2:0] KIND_RCR   = 3'd1;
    localparam logic [2:0] KIND_ROL   = 3'd2;
    localparam logic [2:0] KIND_ROR   = 3'd3;
    localparam logic [2:0] KIND_SHL   = 3'd4;
    localparam logic [2:0] KIND_SHR   = 3'd5;
    localparam logic [2:0] KIND_SAR   = 3'd6;
    localparam logic [2:0] KIND_SPARE = 3'd7;

    // Largest shift amount that still changes anything (word width plus one)
    localparam logic [4:0] SHIFT_MAX = 5'd17;

    // Reciprocal multipliers (scaled by 512, rounded down) for mod 9 and mod 17
    localparam logic [13:0] RECIP_9  = 14'd56;
    localparam logic [12:0] RECIP_17 = 13'd30;

    // Request word
    typedef struct packed {
        logic [2:0]  kind;
        logic        wide;
        logic [15:0] value;
        logic [7:0]  count;
        logic        carry_in;
        logic        overflow_in;
    } op_t;

    // Response word
    typedef struct packed {
        logic [15:0] result;
        logic        carry_out;
        logic        overflow_out;
        logic        sign_out;
        logic        zero_out;
        logic        parity_out;
    } res_t;

    // Decode stage to shifter stage
    typedef struct packed {
        logic [2:0]  kind;
        logic        wide;
        logic [15:0] value;
        logic        carry_in;
        logic        overflow_in;
        logic        pass;
        logic        one;
        logic [4:0]  amount;
    } dec_t;

    // Shifter stage to flag stage
    typedef struct packed {
        logic [2:0]  kind;
        logic        wide;
        logic [15:0] result;
        logic        carry;
        logic        carry_in;
        logic        overflow_in;
        logic        orig_msb;
        logic        one;
    } shf_t;

endpackage

/* design/x86_shift_rotate_unit.sv */
// Top level of the 8/16-bit shift and rotate unit.
//
// Usage:
//   The op channel (op_valid, op_ready, op) takes one request word per
//   cycle: operation kind, operand width, value, count and the current
//   CF and OF. The res channel (res_valid, res_ready, res) returns one
//   response word per request, in order: masked result, CF, OF, SF, ZF, PF.
//   The three register stages are count decode, barrel shift, and flag
//   generation into the output register; res_valid rises once a request
//   has passed through all three. Throughput is one word per cycle while
//   res_ready stays high.
//   A stall on res_ready holds the output register; words behind it fill
//   empty stages and op_ready falls once all three stages are full, so
//   nothing is dropped or repeated.
//   Reset clears the stage valid bits only; the data registers are not
//   reset, and the unit is ready in the first cycle after reset.
module x86_shift_rotate_unit (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          op_valid,
    output logic          op_ready,
    input  sru_pkg::op_t  op,
    output logic          res_valid,
    input  logic          res_ready,
    output sru_pkg::res_t res
);

    logic          dec_valid;
    logic          dec_ready;
    sru_pkg::dec_t dec_data;
    logic          shf_valid;
    logic          shf_ready;
    sru_pkg::shf_t shf_data;

    // Decode the count
    sru_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (op_valid),
        .ready_out (op_ready),
        .data_in   (op),
        .valid_out (dec_valid),
        .ready_in  (dec_ready),
        .data_out  (dec_data)
    );

    // Rotate or shift
    sru_shifter u_shifter (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (dec_valid),
        .ready_out (dec_ready),
        .data_in   (dec_data),
        .valid_out (shf_valid),
        .ready_in  (shf_ready),
        .data_out  (shf_data)
    );

    // Generate flags and hold the response
    sru_flags u_flags (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (shf_valid),
        .ready_out (shf_ready),
        .data_in   (shf_data),
        .valid_out (res_valid),
        .ready_in  (res_ready),
        .data_out  (res)
    );

endmodule

/* design/sru_decode.sv */
// First stage: count reduction and left-rotate amount.
`include "assert_macros.svh"
module sru_decode (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          valid_in,
    output logic          ready_out,
    input  sru_pkg::op_t  data_in,
    output logic          valid_out,
    input  logic          ready_in,
    output sru_pkg::dec_t data_out
);

    logic          valid_reg;
    logic          valid_next;
    sru_pkg::dec_t data_reg;
    sru_pkg::dec_t data_next;

    // Take a new word when the stage is empty or its word moves on
    assign ready_out  = !valid_reg || ready_in;
    assign valid_next = ready_out ? valid_in : valid_reg;

    // Reduce the count and turn right rotates into left rotates
    always_comb
    begin
        logic [7:0]  n;
        logic [13:0] p9;
        logic [12:0] p17;
        logic [7:0]  m9;
        logic [7:0]  m17;
        logic [7:0]  r9;
        logic [7:0]  r17;
        logic [4:0]  rot_mod;
        logic [4:0]  rc_mod;
        logic [4:0]  rot_len;
        logic [4:0]  rc_len;

        n   = data_in.count;
        p9  = {6'd0, n} * sru_pkg::RECIP_9;
        p17 = {5'd0, n} * sru_pkg::RECIP_17;
        m9  = 8'(p9[13:9]) * 8'd9;
        m17 = 8'(p17[12:9]) * 8'd17;
        r9  = n - m9;
        r17 = n - m17;
        // quotient estimate may be one low: correct once
        if (r9 >= 8'd9)
        begin
            r9 = r9 - 8'd9;
        end
        if (r17 >= 8'd17)
        begin
            r17 = r17 - 8'd17;
        end

        rot_len = data_in.wide ? 5'd16 : 5'd8;
        rc_len  = data_in.wide ? 5'd17 : 5'd9;
        rot_mod = data_in.wide ? {1'b0, n[3:0]} : {2'b00, n[2:0]};
        rc_mod  = data_in.wide ? r17[4:0] : r9[4:0];

        data_next.kind        = data_in.kind;
        data_next.wide        = data_in.wide;
        data_next.value       = data_in.wide ? data_in.value : {8'h00, data_in.value[7:0]};
        data_next.carry_in    = data_in.carry_in;
        data_next.overflow_in = data_in.overflow_in;
        data_next.pass        = (n == 8'd0) || (data_in.kind == sru_pkg::KIND_SPARE);
        data_next.one         = (n == 8'd1) && (data_in.kind != sru_pkg::KIND_SPARE);

        case (data_in.kind)
            sru_pkg::KIND_RCL: data_next.amount = rc_mod;
            sru_pkg::KIND_RCR: data_next.amount = (rc_mod == 5'd0) ? 5'd0 : rc_len - rc_mod;
            sru_pkg::KIND_ROL: data_next.amount = rot_mod;
            sru_pkg::KIND_ROR: data_next.amount = (rot_mod == 5'd0) ? 5'd0 : rot_len - rot_mod;
            default:
                data_next.amount = (n > 8'(sru_pkg::SHIFT_MAX)) ? sru_pkg::SHIFT_MAX : n[4:0];
        endcase
    end

    // Hold or advance the stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (valid_in && ready_out)
        begin
            data_reg <= data_next;
        end
    end

    assign valid_out = valid_reg;
    assign data_out  = data_reg;

    `SRU_NEVER(dec_pass_and_one, valid_reg && data_reg.pass && data_reg.one)
    `SRU_ASSERT(dec_amount_range, valid_reg |-> (data_reg.amount <= sru_pkg::SHIFT_MAX))

endmodule

/* design/sru_shifter.sv */
// Second stage: barrel rotate and shift with the new carry.
`include "assert_macros.svh"
module sru_shifter (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          valid_in,
    output logic          ready_out,
    input  sru_pkg::dec_t data_in,
    output logic          valid_out,
    input  logic          ready_in,
    output sru_pkg::shf_t data_out
);

    logic          valid_reg;
    logic          valid_next;
    sru_pkg::shf_t data_reg;
    sru_pkg::shf_t data_next;

    assign ready_out  = !valid_reg || ready_in;
    assign valid_next = ready_out ? valid_in : valid_reg;

    // Rotate left at 8, 9, 16 or 17 bits, or shift by the clamped amount
    always_comb
    begin
        logic [15:0] v;
        logic [4:0]  amt;
        logic [15:0] d8;
        logic [17:0] d9;
        logic [31:0] d16;
        logic [33:0] d17;
        logic [33:0] tl;
        logic [16:0] tr;
        logic [33:0] ta;
        logic        s;
        logic [15:0] ext;
        logic [15:0] res;
        logic        cf;

        v   = data_in.value;
        amt = data_in.amount;
        d8  = {v[7:0], v[7:0]} << amt;
        d9  = {data_in.carry_in, v[7:0], data_in.carry_in, v[7:0]} << amt;
        d16 = {v, v} << amt;
        d17 = {data_in.carry_in, v, data_in.carry_in, v} << amt;
        tl  = {18'd0, v} << amt;
        tr  = {v, 1'b0} >> amt;
        s   = data_in.wide ? v[15] : v[7];
        ext = data_in.wide ? v : {{8{s}}, v[7:0]};
        ta  = {{17{s}}, ext, 1'b0} >> amt;

        case (data_in.kind) inside
            sru_pkg::KIND_RCL, sru_pkg::KIND_RCR:
            begin
                if (data_in.wide)
                begin
                    res = d17[32:17];
                    cf  = d17[33];
                end
                else
                begin
                    res = {8'h00, d9[16:9]};
                    cf  = d9[17];
                end
            end
            sru_pkg::KIND_ROL, sru_pkg::KIND_ROR:
            begin
                res = data_in.wide ? d16[31:16] : {8'h00, d8[15:8]};
                if (data_in.kind == sru_pkg::KIND_ROL)
                begin
                    cf = res[0];
                end
                else
                begin
                    cf = data_in.wide ? res[15] : res[7];
                end
            end
            sru_pkg::KIND_SHL:
            begin
                res = data_in.wide ? tl[15:0] : {8'h00, tl[7:0]};
                cf  = data_in.wide ? tl[16] : tl[8];
            end
            sru_pkg::KIND_SHR:
            begin
                res = tr[16:1];
                cf  = tr[0];
            end
            default:
            begin
                res = data_in.wide ? ta[16:1] : {8'h00, ta[8:1]};
                cf  = ta[0];
            end
        endcase

        // Zero count and the spare code leave operand and carry alone
        if (data_in.pass)
        begin
            res = v;
            cf  = data_in.carry_in;
        end

        data_next.kind        = data_in.kind;
        data_next.wide        = data_in.wide;
        data_next.result      = res;
        data_next.carry       = cf;
        data_next.carry_in    = data_in.carry_in;
        data_next.overflow_in = data_in.overflow_in;
        data_next.orig_msb    = s;
        data_next.one         = data_in.one;
    end

    // Hold or advance the stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (valid_in && ready_out)
        begin
            data_reg <= data_next;
        end
    end

    assign valid_out = valid_reg;
    assign data_out  = data_reg;

    `SRU_ASSERT(shf_byte_upper_clear,
        (valid_reg && !data_reg.wide) |-> (data_reg.result[15:8] == 8'h00))

endmodule

/* design/sru_flags.sv */
// Third stage: overflow, sign, zero and parity flags; output register.
`include "assert_macros.svh"
module sru_flags (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          valid_in,
    output logic          ready_out,
    input  sru_pkg::shf_t data_in,
    output logic          valid_out,
    input  logic          ready_in,
    output sru_pkg::res_t data_out
);

    logic          valid_reg;
    logic          valid_next;
    sru_pkg::res_t data_reg;
    sru_pkg::res_t data_next;

    assign ready_out  = !valid_reg || ready_in;
    assign valid_next = ready_out ? valid_in : valid_reg;

    // Derive the flags from the masked result
    always_comb
    begin
        logic msb;
        logic next_msb;
        logic of;

        msb      = data_in.wide ? data_in.result[15] : data_in.result[7];
        next_msb = data_in.wide ? data_in.result[14] : data_in.result[6];

        case (data_in.kind)
            sru_pkg::KIND_RCR: of = data_in.orig_msb ^ data_in.carry_in;
            sru_pkg::KIND_ROR: of = msb ^ next_msb;
            sru_pkg::KIND_SHR: of = data_in.orig_msb;
            sru_pkg::KIND_SAR: of = 1'b0;
            default:           of = msb ^ data_in.carry;
        endcase

        data_next.result       = data_in.result;
        data_next.carry_out    = data_in.carry;
        data_next.overflow_out = data_in.one ? of : data_in.overflow_in;
        data_next.sign_out     = msb;
        data_next.zero_out     = (data_in.result == 16'h0000);
        data_next.parity_out   = ~^data_in.result[7:0];
    end

    // Hold or advance the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (valid_in && ready_out)
        begin
            data_reg <= data_next;
        end
    end

    assign valid_out = valid_reg;
    assign data_out  = data_reg;

    `SRU_ASSERT(flg_zero_has_even_parity,
        (valid_reg && data_reg.zero_out) |-> data_reg.parity_out)

endmodule
